/* rtl/ising1d_pkg.sv */
// ============================================================================
// ising1d_pkg
// Shared widths, operation codes and control types of the 1-D Ising ring core.
// ============================================================================
package ising1d_pkg;

  // Request field widths
  localparam int OP_W      = 2;
  localparam int SITE_W    = 7;
  localparam int RND_W     = 16;
  localparam int THRESH_W  = 17;

  // Result field widths
  localparam int SUM_W     = 9;
  localparam int ACC_W     = 41;
  localparam int SQ_ACC_W  = 40;
  localparam int CNT_W     = 32;

  // Packed stream widths (payload rounded up to whole bytes)
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 216;
  localparam int OUT_PAD_W  = OUT_DATA_W - (2 + 2 * SUM_W + 2 * ACC_W + 2 * SQ_ACC_W + CNT_W);

  // Register port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register select is paddr bit 2 (one word per register)
  localparam logic REG_THRESH    = 1'b0;
  localparam logic REG_ANTIFERRO = 1'b1;

  // Request kinds
  typedef enum logic [OP_W-1:0] {
    OP_FLIP   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Commands to the statistics unit
  typedef struct packed {
    logic sample;
    logic clear;
  } acc_cmd_t;

endpackage

/* rtl/ising_1d_metropolis_ring_core.sv */
// ============================================================================
// ising_1d_metropolis_ring_core
// Metropolis single-spin-flip engine for a periodic 1-D Ising ring, with
// incremental bond/spin totals and saturating sample statistics.
// ============================================================================
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in_     | slave     | tvalid/tready         | tuser: op; tdata: site, spin,
//          |           |                       |   random word
//  out_    | master    | tvalid/tready         | tdata: flags, totals, stats
//  cfg_    | APB slave | psel/penable/pready   | threshold, antiferro
//
//  For each request, the accept edge reads the site and both neighbors from
//  the lattice memories; the write-back edge then writes the site and loads
//  the result. No new request is taken until that write-back is done.
//  After reset a clearing pass sets all SPINS spins to +1; no request is
//  taken meanwhile. Configuration writes are always taken.
//  A pending result stalls write-back; one request may be held meanwhile.
// ============================================================================
module ising_1d_metropolis_ring_core #(
  parameter int SPINS = 128
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [ising1d_pkg::IN_DATA_W-1:0]     in_tdata,   // site[6:0], spin_value, random_value[15:0]
  input  logic [ising1d_pkg::OP_W-1:0]          in_tuser,   // op[1:0]
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ising1d_pkg::OUT_DATA_W-1:0]    out_tdata,  // accepted, spin_after, bond_sum[8:0],
                                                            // spin_sum[8:0], acc_bond[40:0],
                                                            // acc_bond_sq[39:0], acc_spin[40:0],
                                                            // acc_spin_sq[39:0], sample_count[31:0]
  // register port
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [ising1d_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ising1d_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ising1d_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                  cfg_pready
);
  import ising1d_pkg::*;

  localparam int AW = (SPINS > 1) ? $clog2(SPINS) : 1;
  localparam int CW = ((AW > SITE_W) ? AW : SITE_W) + 1;
  localparam int TW = AW + 2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           clr_cnt_r;

  // Registers
  logic [THRESH_W-1:0]     thresh_r;
  logic                    antiferro_r;
  logic                    cfg_wr;

  // Request fields
  op_t                     in_op;
  logic [SITE_W-1:0]       in_site;
  logic                    in_spin;
  logic [RND_W-1:0]        in_rnd;
  logic [CW-1:0]           site_ext;
  logic [CW-1:0]           left_ext;
  logic [CW-1:0]           right_ext;
  logic                    accept;

  // Captured request
  op_t                     op_r;
  logic                    valid_r;
  logic                    spin_r;
  logic [RND_W-1:0]        rnd_r;
  logic [AW-1:0]           addr_r;

  // Lattice: two copies, written together, three reads per request
  logic                    lat_a [SPINS];
  logic                    lat_b [SPINS];
  logic                    rd_c_r, rd_l_r, rd_rt_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic                    mem_wdata;

  // Update logic
  logic                    step;
  logic                    uphill;
  logic                    rnd_below;
  logic                    do_flip;
  logic signed [TW-1:0]    bond_total_r, bond_total_nxt;
  logic signed [TW-1:0]    spin_total_r, spin_total_nxt;
  logic signed [TW-1:0]    spin_delta;
  logic signed [TW-1:0]    bond_delta;
  logic                    accepted_r;
  logic                    spin_after_r;
  logic                    out_valid_r;
  acc_cmd_t                acc_cmd;

  logic signed [ACC_W-1:0] acc_bond;
  logic [SQ_ACC_W-1:0]     acc_bond_sq;
  logic signed [ACC_W-1:0] acc_spin;
  logic [SQ_ACC_W-1:0]     acc_spin_sq;
  logic [CNT_W-1:0]        sample_count;

  // ---------------------------------------------------------------- registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= '0;
      antiferro_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ANTIFERRO) begin
        antiferro_r <= cfg_pwdata[0];
      end else begin
        thresh_r <= cfg_pwdata[THRESH_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ANTIFERRO) ?
                      {{(CFG_DATA_W-1){1'b0}}, antiferro_r} :
                      {{(CFG_DATA_W-THRESH_W){1'b0}}, thresh_r};

  // ---------------------------------------------------------------- request decode
  assign in_op   = op_t'(in_tuser);
  assign in_site = in_tdata[SITE_W-1:0];
  assign in_spin = in_tdata[SITE_W];
  assign in_rnd  = in_tdata[SITE_W+1 +: RND_W];

  assign site_ext  = CW'(in_site);
  assign left_ext  = (site_ext == '0) ? CW'(SPINS - 1) : site_ext - 1'b1;
  assign right_ext = (site_ext + 1'b1 == CW'(SPINS)) ? '0 : site_ext + 1'b1;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      valid_r <= (site_ext < CW'(SPINS));
      spin_r  <= in_spin;
      rnd_r   <= in_rnd;
      addr_r  <= site_ext[AW-1:0];
    end
  end

  // ---------------------------------------------------------------- lattice memories
  assign mem_we    = (state_r == ST_CLEAR) | (step & do_flip);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? 1'b1 : ~rd_c_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lat_a[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_c_r <= lat_a[site_ext[AW-1:0]];
      rd_l_r <= lat_a[left_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lat_b[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_rt_r <= lat_b[right_ext[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------- sequencing
  assign step = (state_r == ST_EXEC) & (~out_valid_r | out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == AW'(SPINS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_EXEC;
      ST_EXEC:  if (step) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- flip decision
  // Local product is +2 when both neighbors match the site, -2 when both differ
  assign uphill    = (rd_l_r == rd_rt_r) & ((rd_l_r == rd_c_r) ^ antiferro_r);
  assign rnd_below = ({1'b0, rnd_r} < thresh_r);

  always_comb begin
    do_flip = 1'b0;
    case (op_r)
      OP_FLIP:  do_flip = valid_r & (~uphill | rnd_below);
      OP_WRITE: do_flip = valid_r & (rd_c_r != spin_r);
      default:  do_flip = 1'b0;
    endcase
  end

  // Total updates: spin moves by -2s, bonds by -2p
  assign spin_delta = rd_c_r ? -TW'(2) : TW'(2);
  assign bond_delta = (rd_l_r != rd_rt_r) ? '0 :
                      ((rd_l_r == rd_c_r) ? -TW'(4) : TW'(4));

  always_comb begin
    spin_total_nxt = spin_total_r;
    bond_total_nxt = bond_total_r;
    if (step & do_flip) begin
      spin_total_nxt = spin_total_r + spin_delta;
      bond_total_nxt = bond_total_r + bond_delta;
    end
  end

  // ---------------------------------------------------------------- result state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_total_r <= TW'(SPINS);
      bond_total_r <= TW'(SPINS);
      out_valid_r  <= 1'b0;
      accepted_r   <= 1'b0;
      spin_after_r <= 1'b0;
    end else begin
      spin_total_r <= spin_total_nxt;
      bond_total_r <= bond_total_nxt;
      if (step) begin
        out_valid_r  <= 1'b1;
        accepted_r   <= (op_r == OP_FLIP) & do_flip;
        spin_after_r <= valid_r & (rd_c_r ^ do_flip);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- statistics
  assign acc_cmd.sample = step & (op_r == OP_SAMPLE);
  assign acc_cmd.clear  = step & (op_r == OP_CLEAR);

  ising1d_accum #(
    .TW (TW)
  ) u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (acc_cmd),
    .bond_total   (bond_total_r),
    .spin_total   (spin_total_r),
    .acc_bond     (acc_bond),
    .acc_bond_sq  (acc_bond_sq),
    .acc_spin     (acc_spin),
    .acc_spin_sq  (acc_spin_sq),
    .sample_count (sample_count)
  );

  // ---------------------------------------------------------------- result packing
  // State registers change only at a write-back, which waits for the result slot
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}},
                       sample_count,
                       acc_spin_sq,
                       acc_spin,
                       acc_bond_sq,
                       acc_bond,
                       SUM_W'(spin_total_r),
                       SUM_W'(bond_total_r),
                       spin_after_r,
                       accepted_r};

endmodule

/* rtl/ising1d_accum.sv */
// ============================================================================
// ising1d_accum
// Saturating statistics: sums of bond and spin totals, their squares and
// the sample count.
// ============================================================================
module ising1d_accum #(
  parameter int TW = 9
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ising1d_pkg::acc_cmd_t                cmd,
  input  logic signed [TW-1:0]                 bond_total,
  input  logic signed [TW-1:0]                 spin_total,
  output logic signed [ising1d_pkg::ACC_W-1:0] acc_bond,
  output logic [ising1d_pkg::SQ_ACC_W-1:0]     acc_bond_sq,
  output logic signed [ising1d_pkg::ACC_W-1:0] acc_spin,
  output logic [ising1d_pkg::SQ_ACC_W-1:0]     acc_spin_sq,
  output logic [ising1d_pkg::CNT_W-1:0]        sample_count
);
  import ising1d_pkg::*;

  localparam int SQ_W = 2 * TW;

  logic signed [SQ_W-1:0]   bond_prod;
  logic signed [SQ_W-1:0]   spin_prod;
  logic [SQ_W-1:0]          bond_sq_r;
  logic [SQ_W-1:0]          spin_sq_r;

  logic signed [ACC_W:0]    bond_sum;
  logic signed [ACC_W:0]    spin_sum;
  logic [SQ_ACC_W:0]        bond_sq_sum;
  logic [SQ_ACC_W:0]        spin_sq_sum;

  logic signed [ACC_W-1:0]  acc_bond_r,    acc_bond_nxt;
  logic signed [ACC_W-1:0]  acc_spin_r,    acc_spin_nxt;
  logic [SQ_ACC_W-1:0]      acc_bond_sq_r, acc_bond_sq_nxt;
  logic [SQ_ACC_W-1:0]      acc_spin_sq_r, acc_spin_sq_nxt;
  logic [CNT_W-1:0]         samples_r,     samples_nxt;

  // Squares tracked every cycle; totals settle before a sample, so the registered squares match
  assign bond_prod = bond_total * bond_total;
  assign spin_prod = spin_total * spin_total;

  always_ff @(posedge clk) begin
    bond_sq_r <= unsigned'(bond_prod);
    spin_sq_r <= unsigned'(spin_prod);
  end

  // Wide adds with one guard bit for overflow detection
  assign bond_sum    = (ACC_W + 1)'(acc_bond_r) + (ACC_W + 1)'(bond_total);
  assign spin_sum    = (ACC_W + 1)'(acc_spin_r) + (ACC_W + 1)'(spin_total);
  assign bond_sq_sum = {1'b0, acc_bond_sq_r} + (SQ_ACC_W + 1)'(bond_sq_r);
  assign spin_sq_sum = {1'b0, acc_spin_sq_r} + (SQ_ACC_W + 1)'(spin_sq_r);

  // Next values with clamping
  always_comb begin
    acc_bond_nxt    = acc_bond_r;
    acc_spin_nxt    = acc_spin_r;
    acc_bond_sq_nxt = acc_bond_sq_r;
    acc_spin_sq_nxt = acc_spin_sq_r;
    samples_nxt     = samples_r;
    if (cmd.clear) begin
      acc_bond_nxt    = '0;
      acc_spin_nxt    = '0;
      acc_bond_sq_nxt = '0;
      acc_spin_sq_nxt = '0;
      samples_nxt     = '0;
    end else if (cmd.sample) begin
      if (bond_sum[ACC_W] != bond_sum[ACC_W-1]) begin
        acc_bond_nxt = bond_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_bond_nxt = bond_sum[ACC_W-1:0];
      end
      if (spin_sum[ACC_W] != spin_sum[ACC_W-1]) begin
        acc_spin_nxt = spin_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_spin_nxt = spin_sum[ACC_W-1:0];
      end
      acc_bond_sq_nxt = bond_sq_sum[SQ_ACC_W] ? '1 : bond_sq_sum[SQ_ACC_W-1:0];
      acc_spin_sq_nxt = spin_sq_sum[SQ_ACC_W] ? '1 : spin_sq_sum[SQ_ACC_W-1:0];
      if (samples_r != '1) begin
        samples_nxt = samples_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_bond_r    <= '0;
      acc_spin_r    <= '0;
      acc_bond_sq_r <= '0;
      acc_spin_sq_r <= '0;
      samples_r     <= '0;
    end else begin
      acc_bond_r    <= acc_bond_nxt;
      acc_spin_r    <= acc_spin_nxt;
      acc_bond_sq_r <= acc_bond_sq_nxt;
      acc_spin_sq_r <= acc_spin_sq_nxt;
      samples_r     <= samples_nxt;
    end
  end

  assign acc_bond     = acc_bond_r;
  assign acc_spin     = acc_spin_r;
  assign acc_bond_sq  = acc_bond_sq_r;
  assign acc_spin_sq  = acc_spin_sq_r;
  assign sample_count = samples_r;

endmodule
